// ----- src/bmcc_pkg.sv -----
// Shared constants, register index codes and divider status type for the coulomb counter.
package bmcc_pkg;

  // configuration register reset values
  localparam logic [15:0] CUR_ALPHA_RST  = 16'd50817;
  localparam logic [15:0] VOLT_ALPHA_RST = 16'd28556;
  localparam logic [15:0] SLOW_ALPHA_RST = 16'd65208;
  localparam logic [23:0] CUR_GAIN_RST   = 24'd5045760;
  localparam logic [23:0] VOLT_GAIN_RST  = 24'd281274;
  localparam logic [15:0] CAP_MAH_RST    = 16'd4500;
  localparam logic [15:0] LOW_HI_MV_RST  = 16'd11500;
  localparam logic [15:0] LOW_LO_MV_RST  = 16'd8000;

  // sequencing and scaling constants
  localparam logic [7:0]  SETTLE_TICKS   = 8'd255;
  localparam logic [7:0]  CALIB_SAMPLES  = 8'd128;
  localparam logic [31:0] ARM_TICKS      = 32'd15000;
  localparam logic signed [39:0] SLOW_V_RST = 40'sd1101004800; // 16800 mV in Q24.16
  localparam logic [39:0] TICKS_PER_MAH  = 40'd360000;
  localparam logic [13:0] PCT_FULL       = 14'd10000;
  localparam logic [17:0] PCT_SCALE      = 18'd10000;

  // reciprocals for the constant divisions
  localparam logic [39:0] RECIP_1000     = 40'd549755814;    // ceil(2^36/125), on n/8
  localparam logic [39:0] RECIP_360      = 40'd48867183457;  // ceil(2^41/45), on n/8
  localparam logic [48:0] USED_SAT_ABS   = 49'd773094113280; // 360 * 2^31

  // shared divider sizing
  localparam int DIV_DVD_W = 49;
  localparam int DIV_DVS_W = 35;

  typedef enum logic [2:0] {
    CFG_CUR_ALPHA  = 3'd0,
    CFG_VOLT_ALPHA = 3'd1,
    CFG_SLOW_ALPHA = 3'd2,
    CFG_CUR_GAIN   = 3'd3,
    CFG_VOLT_GAIN  = 3'd4,
    CFG_CAP_MAH    = 3'd5,
    CFG_LOW_HI_MV  = 3'd6,
    CFG_LOW_LO_MV  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/bmcc_div.sv -----
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module bmcc_div #(
  parameter int DVD_W = bmcc_pkg::DIV_DVD_W,
  parameter int DVS_W = bmcc_pkg::DIV_DVS_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output logic [DVD_W-1:0]    quotient,
  output bmcc_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] dq_r;   // dividend shifts out, quotient shifts in
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, dq_r[DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_sub[DVS_W-1:0];
      dq_r  <= {dq_r[DVD_W-2:0], ge};
    end
  end

  assign quotient  = dq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- src/battery_monitor_coulomb_counter.sv -----
// Coulomb-counting battery monitor top level: sequencer, shared multiplier and state.
// One item is in work at a time: a new input is taken only once the last result has
// been handed to the output register. The work is done by the 15-step sequencer on the
// shared multiplier (power /1000 and used charge /360 as reciprocal passes) plus the
// 49-step divider for the percent.
// Reset (rst_n low, synchronous) restores register defaults and clears all filter,
// calibration and charge state; the slow voltage smoother restarts at 16800 mV.
module battery_monitor_coulomb_counter (
  input  logic               clk,
  input  logic               rst_n,
  // input transaction
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        in_current_code,
  input  logic [11:0]        in_voltage_code,
  input  logic [31:0]        in_system_ticks,
  // result transaction
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [19:0] out_current_ma,
  output logic [14:0]        out_voltage_mv,
  output logic [14:0]        out_slow_voltage_mv,
  output logic signed [23:0] out_power_mw,
  output logic signed [31:0] out_used_charge_uah,
  output logic [13:0]        out_percent_left,
  output logic               out_low_battery,
  output logic               out_calibrated,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int DVD_W = bmcc_pkg::DIV_DVD_W;
  localparam int DVS_W = bmcc_pkg::DIV_DVS_W;

  // Sequencer: at most one multiply per state, divider waits in DIVQ.
  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_MULI = 18'h00002,  // raw current = -(code * gain)
    ST_MULV = 18'h00004,  // raw voltage = code * gain
    ST_CAL  = 18'h00008,  // settle / calibration bookkeeping
    ST_FILC = 18'h00010,  // current smoother
    ST_FILV = 18'h00020,  // fast voltage smoother
    ST_FILS = 18'h00040,  // slow voltage smoother, low battery check
    ST_CAP  = 18'h00080,  // capacity in mA*ticks, rounding to output units
    ST_ACC  = 18'h00100,  // charge accumulation
    ST_PWR  = 18'h00200,  // current * voltage, capture reciprocal operands
    ST_RP0  = 18'h00400,  // power /1000, low partial product
    ST_RP1  = 18'h00800,  // power /1000, high partial product
    ST_RC0  = 18'h01000,  // store power; charge /360, low partial product
    ST_RC1  = 18'h02000,  // charge /360, middle partial product
    ST_RC2  = 18'h04000,  // charge /360, top partial product
    ST_PCT  = 18'h08000,  // store used charge, remaining fraction, maybe divide
    ST_DIVQ = 18'h10000,  // wait percent
    ST_DONE = 18'h20000   // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] cur_alpha_r, volt_alpha_r, slow_alpha_r;
  logic [23:0] cur_gain_r, volt_gain_r;
  logic [15:0] cap_mah_r, low_hi_r, low_lo_r;

  // per-item captures and intermediates
  logic [11:0]        ccode_r, vcode_r;
  logic [31:0]        ticks_r;
  logic signed [39:0] raw_i_r, raw_v_r, x_r;
  logic               filt_en_r;
  logic [34:0]        cap_r;
  logic signed [19:0] cur_ma_r;
  logic [14:0]        vmv_r, vsmv_r;
  logic signed [23:0] pw_r;
  logic signed [31:0] used_r;
  logic               pw_neg_r, chg_neg_r, chg_big_r;
  logic [29:0]        pn_r;    // |power product| / 8
  logic [36:0]        cn_r;    // |charge| / 8
  logic [72:0]        acc_r;   // reciprocal product accumulator

  // long-lived state
  logic [7:0]         settle_cnt_r, calib_cnt_r;
  logic signed [47:0] calib_sum_r;
  logic signed [39:0] offset_r, cf_r, vf_r, sf_r;
  logic signed [47:0] charge_r;
  logic [13:0]        percent_held_r;
  logic               low_bat_r;

  logic out_valid_r;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, writes land in the cycle after they are offered.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_alpha_r  <= bmcc_pkg::CUR_ALPHA_RST;
      volt_alpha_r <= bmcc_pkg::VOLT_ALPHA_RST;
      slow_alpha_r <= bmcc_pkg::SLOW_ALPHA_RST;
      cur_gain_r   <= bmcc_pkg::CUR_GAIN_RST;
      volt_gain_r  <= bmcc_pkg::VOLT_GAIN_RST;
      cap_mah_r    <= bmcc_pkg::CAP_MAH_RST;
      low_hi_r     <= bmcc_pkg::LOW_HI_MV_RST;
      low_lo_r     <= bmcc_pkg::LOW_LO_MV_RST;
    end else if (cfg_valid) begin
      unique case (bmcc_pkg::cfg_idx_t'(cfg_index))
        bmcc_pkg::CFG_CUR_ALPHA:  cur_alpha_r  <= cfg_data[15:0];
        bmcc_pkg::CFG_VOLT_ALPHA: volt_alpha_r <= cfg_data[15:0];
        bmcc_pkg::CFG_SLOW_ALPHA: slow_alpha_r <= cfg_data[15:0];
        bmcc_pkg::CFG_CUR_GAIN:   cur_gain_r   <= cfg_data;
        bmcc_pkg::CFG_VOLT_GAIN:  volt_gain_r  <= cfg_data;
        bmcc_pkg::CFG_CAP_MAH:    cap_mah_r    <= cfg_data[15:0];
        bmcc_pkg::CFG_LOW_HI_MV:  low_hi_r     <= cfg_data[15:0];
        bmcc_pkg::CFG_LOW_LO_MV:  low_lo_r     <= cfg_data[15:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared 40x18 signed multiplier. Operands are chosen by state; the product
  // is consumed into a register in the same state. The constant divisions run
  // as reciprocal multiplies, one operand slice per pass.
  // ---------------------------------------------------------------------------
  logic signed [39:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [57:0] prod;
  logic signed [57:0] prod_rnd;
  logic signed [39:0] smooth_q;   // floor((a*d + 2^15) / 2^16)
  logic [72:0]        prod_ext;
  logic [15:0]        cap_eff;

  // offset-corrected current and the remaining-capacity difference
  logic signed [47:0] off_new;
  logic signed [39:0] off_eff;
  logic signed [48:0] diff;
  logic               diff_pos, diff_ge_cap;

  assign cap_eff = (cap_mah_r == 16'd0) ? 16'd1 : cap_mah_r;
  assign diff    = $signed({14'd0, cap_r}) - $signed({charge_r[47], charge_r});
  assign diff_pos    = !diff[48] && (diff != '0);
  assign diff_ge_cap = diff[47:0] >= {13'd0, cap_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MULI: begin
        mul_a = $signed({16'd0, cur_gain_r});
        mul_b = $signed({6'd0, ccode_r});
      end
      ST_MULV: begin
        mul_a = $signed({16'd0, volt_gain_r});
        mul_b = $signed({6'd0, vcode_r});
      end
      ST_FILC: begin
        mul_a = cf_r - x_r;
        mul_b = $signed({2'd0, cur_alpha_r});
      end
      ST_FILV: begin
        mul_a = vf_r - raw_v_r;
        mul_b = $signed({2'd0, volt_alpha_r});
      end
      ST_FILS: begin
        mul_a = sf_r - vf_r;
        mul_b = $signed({2'd0, slow_alpha_r});
      end
      ST_CAP: begin
        mul_a = $signed(bmcc_pkg::TICKS_PER_MAH);
        mul_b = $signed({2'd0, cap_eff});
      end
      ST_PWR: begin
        mul_a = {{20{cur_ma_r[19]}}, cur_ma_r};
        mul_b = $signed({3'd0, vmv_r});
      end
      ST_RP0: begin
        mul_a = $signed(bmcc_pkg::RECIP_1000);
        mul_b = $signed({3'd0, pn_r[14:0]});
      end
      ST_RP1: begin
        mul_a = $signed(bmcc_pkg::RECIP_1000);
        mul_b = $signed({3'd0, pn_r[29:15]});
      end
      ST_RC0: begin
        mul_a = $signed(bmcc_pkg::RECIP_360);
        mul_b = $signed({1'b0, cn_r[16:0]});
      end
      ST_RC1: begin
        mul_a = $signed(bmcc_pkg::RECIP_360);
        mul_b = $signed({1'b0, cn_r[33:17]});
      end
      ST_RC2: begin
        mul_a = $signed(bmcc_pkg::RECIP_360);
        mul_b = $signed({15'd0, cn_r[36:34]});
      end
      ST_PCT: begin
        mul_a = $signed({5'd0, diff[34:0]});
        mul_b = $signed(bmcc_pkg::PCT_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_rnd = (prod + 58'sd32768) >>> 16;
  assign smooth_q = prod_rnd[39:0];
  assign prod_ext = {15'd0, prod};  // reciprocal passes have non-negative products

  // offset is sum/128 floored, taken on the first tick after calibration
  assign off_new = calib_sum_r >>> 7;
  assign off_eff = (calib_cnt_r == bmcc_pkg::CALIB_SAMPLES) ? off_new[39:0] : offset_r;

  // ---------------------------------------------------------------------------
  // Rounding of the filter states to output units, with saturation.
  // ---------------------------------------------------------------------------
  logic signed [39:0] cur_rnd, v_rnd, vs_rnd;
  logic signed [19:0] cur_sat;
  logic [14:0]        v_sat, vs_sat;

  assign cur_rnd = (cf_r + 40'sd32768) >>> 16;
  assign v_rnd   = (vf_r + 40'sd32768) >>> 16;
  assign vs_rnd  = (sf_r + 40'sd32768) >>> 16;

  always_comb begin
    if (cur_rnd > 40'sd400000)       cur_sat = 20'sd400000;
    else if (cur_rnd < -40'sd400000) cur_sat = -20'sd400000;
    else                             cur_sat = cur_rnd[19:0];
    if (v_rnd < 40'sd0)              v_sat = 15'd0;
    else if (v_rnd > 40'sd20000)     v_sat = 15'd20000;
    else                             v_sat = v_rnd[14:0];
    if (vs_rnd < 40'sd0)             vs_sat = 15'd0;
    else if (vs_rnd > 40'sd20000)    vs_sat = 15'd20000;
    else                             vs_sat = vs_rnd[14:0];
  end

  // charge accumulation with 48-bit saturation
  logic signed [48:0] chg_sum;
  logic signed [47:0] chg_sat;

  assign chg_sum = {charge_r[47], charge_r} + {{29{cur_ma_r[19]}}, cur_ma_r};
  always_comb begin
    if (chg_sum[48] != chg_sum[47])
      chg_sat = chg_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else
      chg_sat = chg_sum[47:0];
  end

  // ---------------------------------------------------------------------------
  // Divider: 10000*diff / cap only. Power and used charge come from the
  // reciprocal passes on magnitudes, so both truncate toward zero.
  // ---------------------------------------------------------------------------
  logic                div_start;
  logic [DVD_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic [DVD_W-1:0]    div_q;
  bmcc_pkg::div_stat_t div_stat;
  logic [57:0]         prod_abs;
  logic [48:0]         chg_abs;

  assign prod_abs = prod[57] ? 58'(-prod) : 58'(prod);
  assign chg_abs  = charge_r[47] ? 49'(-{charge_r[47], charge_r})
                                 : {1'b0, charge_r};

  assign div_start = (state_r == ST_PCT) && diff_pos && !diff_ge_cap;
  assign div_dvd   = prod[DVD_W-1:0];
  assign div_dvs   = cap_r;

  bmcc_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // signed results from the unsigned reciprocal quotients
  logic [23:0]        pw_q;
  logic [31:0]        used_q;
  logic signed [23:0] pw_val;
  logic signed [31:0] used_val;

  assign pw_q   = acc_r[59:36];
  assign used_q = {1'b0, acc_r[71:41]};

  always_comb begin
    if (pw_q > 24'd8000000)
      pw_val = pw_neg_r ? -24'sd8000000 : 24'sd8000000;
    else
      pw_val = pw_neg_r ? 24'(-pw_q) : pw_q;
    // a magnitude of 360 * 2^31 or more saturates either way
    if (chg_big_r)
      used_val = chg_neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else
      used_val = chg_neg_r ? 32'(-used_q) : used_q;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MULI;
      ST_MULI: state_nxt = ST_MULV;
      ST_MULV: state_nxt = ST_CAL;
      ST_CAL:  state_nxt = ST_FILC;
      ST_FILC: state_nxt = ST_FILV;
      ST_FILV: state_nxt = ST_FILS;
      ST_FILS: state_nxt = ST_CAP;
      ST_CAP:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_PWR;
      ST_PWR:  state_nxt = ST_RP0;
      ST_RP0:  state_nxt = ST_RP1;
      ST_RP1:  state_nxt = ST_RC0;
      ST_RC0:  state_nxt = ST_RC1;
      ST_RC1:  state_nxt = ST_RC2;
      ST_RC2:  state_nxt = ST_PCT;
      ST_PCT:  state_nxt = (diff_pos && !diff_ge_cap) ? ST_DIVQ : ST_DONE;
      ST_DIVQ: if (div_stat.done) state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      settle_cnt_r   <= '0;
      calib_cnt_r    <= '0;
      calib_sum_r    <= '0;
      offset_r       <= '0;
      cf_r           <= '0;
      vf_r           <= '0;
      sf_r           <= bmcc_pkg::SLOW_V_RST;
      charge_r       <= '0;
      percent_held_r <= '0;
      low_bat_r      <= 1'b0;
      filt_en_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;

      unique case (state_r)
        ST_CAL: begin
          filt_en_r <= 1'b0;
          if (settle_cnt_r < bmcc_pkg::SETTLE_TICKS) begin
            settle_cnt_r <= settle_cnt_r + 1'b1;
          end else if (calib_cnt_r < bmcc_pkg::CALIB_SAMPLES) begin
            calib_cnt_r <= calib_cnt_r + 1'b1;
            calib_sum_r <= calib_sum_r + {{8{raw_i_r[39]}}, raw_i_r};
          end else begin
            if (calib_cnt_r == bmcc_pkg::CALIB_SAMPLES) begin
              offset_r    <= off_new[39:0];
              calib_cnt_r <= calib_cnt_r + 1'b1;
            end
            filt_en_r <= 1'b1;
          end
        end
        ST_FILC: if (filt_en_r) cf_r <= x_r + smooth_q;
        ST_FILV: vf_r <= raw_v_r + smooth_q;
        ST_FILS: begin
          sf_r <= vf_r + smooth_q;
          if (ticks_r > bmcc_pkg::ARM_TICKS &&
              vf_r < $signed({8'd0, low_hi_r, 16'd0}) &&
              vf_r > $signed({8'd0, low_lo_r, 16'd0}))
            low_bat_r <= 1'b1;
        end
        ST_ACC: charge_r <= chg_sat;
        ST_PCT: if (diff_pos && diff_ge_cap) percent_held_r <= bmcc_pkg::PCT_FULL;
        ST_DIVQ: if (div_stat.done) percent_held_r <= div_q[13:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ccode_r <= in_current_code;
      vcode_r <= in_voltage_code;
      ticks_r <= in_system_ticks;
    end
    if (state_r == ST_MULI) raw_i_r <= 40'(-prod);
    if (state_r == ST_MULV) raw_v_r <= prod[39:0];
    if (state_r == ST_CAL)  x_r <= raw_i_r - off_eff;
    if (state_r == ST_CAP) begin
      cap_r    <= prod[34:0];
      cur_ma_r <= cur_sat;
      vmv_r    <= v_sat;
      vsmv_r   <= vs_sat;
    end
    if (state_r == ST_PWR) begin
      pw_neg_r  <= prod[57];
      pn_r      <= prod_abs[32:3];
      chg_neg_r <= charge_r[47];
      cn_r      <= chg_abs[39:3];
      chg_big_r <= chg_abs >= bmcc_pkg::USED_SAT_ABS;
    end
    // reciprocal partial products: power in two 15-bit slices, charge in two 17-bit slices and a 3-bit top slice
    case (state_r)
      ST_RP0:  acc_r <= prod_ext;
      ST_RP1:  acc_r <= acc_r + (prod_ext << 15);
      ST_RC0:  acc_r <= prod_ext;
      ST_RC1:  acc_r <= acc_r + (prod_ext << 17);
      ST_RC2:  acc_r <= acc_r + (prod_ext << 34);
      default: acc_r <= acc_r;
    endcase
    if (state_r == ST_RC0) pw_r <= pw_val;
    if (state_r == ST_PCT) used_r <= used_val;
    if (out_load) begin
      out_current_ma      <= cur_ma_r;
      out_voltage_mv      <= vmv_r;
      out_slow_voltage_mv <= vsmv_r;
      out_power_mw        <= pw_r;
      out_used_charge_uah <= used_r;
      out_percent_left    <= percent_held_r;
      out_low_battery     <= low_bat_r;
      out_calibrated      <= calib_cnt_r > bmcc_pkg::CALIB_SAMPLES;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MULI))
    else $error("accepted transaction did not start the sequencer");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    percent_held_r <= bmcc_pkg::PCT_FULL)
    else $error("held percent above full scale");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_cal_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_calibrated) |-> (calib_cnt_r > bmcc_pkg::CALIB_SAMPLES))
    else $error("calibrated flag without finished calibration");

endmodule

// ----- verif/bmcc_checker.sv -----
// Checker for the coulomb counter: watches all channels, predicts each result and compares.
module bmcc_checker
  import bmcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [11:0]        in_current_code,
  input  logic [11:0]        in_voltage_code,
  input  logic [31:0]        in_system_ticks,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [19:0] out_current_ma,
  input  logic [14:0]        out_voltage_mv,
  input  logic [14:0]        out_slow_voltage_mv,
  input  logic signed [23:0] out_power_mw,
  input  logic signed [31:0] out_used_charge_uah,
  input  logic [13:0]        out_percent_left,
  input  logic               out_low_battery,
  input  logic               out_calibrated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [19:0] current_ma;
    logic [14:0]        voltage_mv;
    logic [14:0]        slow_voltage_mv;
    logic signed [23:0] power_mw;
    logic signed [31:0] used_charge_uah;
    logic [13:0]        percent_left;
    logic               low_battery;
    logic               calibrated;
  } gauge_reading_t;

  localparam longint CHARGE_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint CHARGE_MIN = -CHARGE_MAX - 1;

  // register copies
  logic [15:0] r_cur_alpha, r_volt_alpha, r_slow_alpha, r_cap_mah, r_low_hi, r_low_lo;
  logic [23:0] r_cur_gain, r_volt_gain;

  // gauge state
  int     settled, calib_taken;
  longint calib_acc, offset, cur_filt, volt_filt, slow_filt, charge;
  int     pct_held;
  bit     low_flag;

  gauge_reading_t readings_due[$];

  function automatic longint ema(longint prev, longint x, logic [15:0] a);
    longint s;
    s = longint'(a) * prev + (64'sd65536 - longint'(a)) * x + 64'sd32768;
    return s >>> 16;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic gauge_reading_t gauge_tick(logic [11:0] cc, logic [11:0] vc,
                                                logic [31:0] ticks);
    longint raw_i, raw_v, cur, vmv, vsmv, pw, used, cap;
    gauge_reading_t r;
    raw_i = -(longint'(cc) * longint'(r_cur_gain));
    raw_v = longint'(vc) * longint'(r_volt_gain);
    if (settled < 255) begin
      settled++;
    end else if (calib_taken < 128) begin
      calib_taken++;
      calib_acc += raw_i;
    end else begin
      if (calib_taken == 128) begin
        offset = calib_acc >>> 7;
        calib_taken++;
      end
      cur_filt = ema(cur_filt, raw_i - offset, r_cur_alpha);
    end
    volt_filt = ema(volt_filt, raw_v, r_volt_alpha);
    slow_filt = ema(slow_filt, volt_filt, r_slow_alpha);

    cur  = clip((cur_filt + 32768) >>> 16, -400000, 400000);
    vmv  = clip((volt_filt + 32768) >>> 16, 0, 20000);
    vsmv = clip((slow_filt + 32768) >>> 16, 0, 20000);
    pw   = clip(cur * vmv / 1000, -8000000, 8000000);

    charge = clip(charge + cur, CHARGE_MIN, CHARGE_MAX);
    used   = clip(charge / 360, -64'sd2147483648, 64'sd2147483647);

    // zero capacity counts as one mAh
    cap = longint'(r_cap_mah == 0 ? 16'd1 : r_cap_mah) * 360000;
    if (cap > charge)
      pct_held = int'(clip((cap - charge) * 10000 / cap, 0, 10000));

    if (ticks > 32'd15000 && volt_filt < longint'(r_low_hi) * 65536 &&
        volt_filt > longint'(r_low_lo) * 65536)
      low_flag = 1'b1;

    r.current_ma      = cur[19:0];
    r.voltage_mv      = vmv[14:0];
    r.slow_voltage_mv = vsmv[14:0];
    r.power_mw        = pw[23:0];
    r.used_charge_uah = used[31:0];
    r.percent_left    = pct_held[13:0];
    r.low_battery     = low_flag;
    r.calibrated      = calib_taken > 128;
    return r;
  endfunction

  task automatic field_check(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  assign outstanding = readings_due.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    gauge_reading_t want;
    if (!rst_n) begin
      r_cur_alpha  <= CUR_ALPHA_RST;
      r_volt_alpha <= VOLT_ALPHA_RST;
      r_slow_alpha <= SLOW_ALPHA_RST;
      r_cur_gain   <= CUR_GAIN_RST;
      r_volt_gain  <= VOLT_GAIN_RST;
      r_cap_mah    <= CAP_MAH_RST;
      r_low_hi     <= LOW_HI_MV_RST;
      r_low_lo     <= LOW_LO_MV_RST;
      settled = 0;
      calib_taken = 0;
      calib_acc = 0;
      offset = 0;
      cur_filt = 0;
      volt_filt = 0;
      slow_filt = 64'sd16800 * 65536;
      charge = 0;
      pct_held = 0;
      low_flag = 1'b0;
      readings_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CUR_ALPHA:  r_cur_alpha  <= cfg_data[15:0];
          CFG_VOLT_ALPHA: r_volt_alpha <= cfg_data[15:0];
          CFG_SLOW_ALPHA: r_slow_alpha <= cfg_data[15:0];
          CFG_CUR_GAIN:   r_cur_gain   <= cfg_data;
          CFG_VOLT_GAIN:  r_volt_gain  <= cfg_data;
          CFG_CAP_MAH:    r_cap_mah    <= cfg_data[15:0];
          CFG_LOW_HI_MV:  r_low_hi     <= cfg_data[15:0];
          CFG_LOW_LO_MV:  r_low_lo     <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        readings_due.push_back(gauge_tick(in_current_code, in_voltage_code, in_system_ticks));
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result transaction, current_ma actual %0d",
                   $time, out_current_ma);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          field_check("current_ma", want.current_ma, out_current_ma);
          field_check("voltage_mv", want.voltage_mv, out_voltage_mv);
          field_check("slow_voltage_mv", want.slow_voltage_mv, out_slow_voltage_mv);
          field_check("power_mw", want.power_mw, out_power_mw);
          field_check("used_charge_uah", want.used_charge_uah, out_used_charge_uah);
          field_check("percent_left", want.percent_left, out_percent_left);
          field_check("low_battery", want.low_battery, out_low_battery);
          field_check("calibrated", want.calibrated, out_calibrated);
        end
      end
    end
  end

endmodule

// ----- verif/tb_battery_monitor_coulomb_counter.sv -----
// Testbench top for the coulomb counter: clock, reset, stimulus, back-pressure and verdict.
module tb_battery_monitor_coulomb_counter;
  import bmcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [11:0]        in_current_code = '0;
  logic [11:0]        in_voltage_code = '0;
  logic [31:0]        in_system_ticks = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [19:0] out_current_ma;
  logic [14:0]        out_voltage_mv;
  logic [14:0]        out_slow_voltage_mv;
  logic signed [23:0] out_power_mw;
  logic signed [31:0] out_used_charge_uah;
  logic [13:0]        out_percent_left;
  logic               out_low_battery;
  logic               out_calibrated;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  int mismatches;
  int outstanding;

  // idle percentages for sender and receiver, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  // longest result latency (percent division path) plus margin
  localparam int DRAIN_CYCLES = 200;

  always #1 clk = ~clk;

  battery_monitor_coulomb_counter dut (.*);

  bmcc_checker u_checker (.*);

  // run limit, far above the slowest legal run
  initial begin
    #4000000;
    $display("tb_battery_monitor_coulomb_counter: errors");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one input transaction; valid stays up back to back unless the sender idles
  task automatic send_tick(logic [11:0] cc, logic [11:0] vc, logic [31:0] ticks);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_current_code <= cc;
    in_voltage_code <= vc;
    in_system_ticks <= ticks;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // block must be idle: all results back and any tail work finished
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(logic [15:0] ca, logic [15:0] va, logic [15:0] sa,
                               logic [23:0] cg, logic [23:0] vg, logic [15:0] cap,
                               logic [15:0] hi, logic [15:0] lo);
    write_reg(CFG_CUR_ALPHA, ca);
    write_reg(CFG_VOLT_ALPHA, va);
    write_reg(CFG_SLOW_ALPHA, sa);
    write_reg(CFG_CUR_GAIN, cg);
    write_reg(CFG_VOLT_GAIN, vg);
    write_reg(CFG_CAP_MAH, cap);
    write_reg(CFG_LOW_HI_MV, hi);
    write_reg(CFG_LOW_LO_MV, lo);
  endtask

  function automatic logic [11:0] pick_code();
    case ($urandom_range(9))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'(1 << $urandom_range(11));
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_ticks();
    case ($urandom_range(5))
      0: return 32'd15000 + $urandom_range(1) ;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(30000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [11:0] edge_codes [4];
    logic [31:0] edge_ticks [4];
    edge_codes = '{12'd0, 12'd1, 12'd2048, 12'hFFF};
    edge_ticks = '{32'd0, 32'd15000, 32'd15001, 32'hFFFF_FFFF};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults written explicitly once
    load_settings(CUR_ALPHA_RST, VOLT_ALPHA_RST, SLOW_ALPHA_RST, CUR_GAIN_RST,
                  VOLT_GAIN_RST, CAP_MAH_RST, LOW_HI_MV_RST, LOW_LO_MV_RST);

    // directed: field extremes against the arming threshold
    foreach (edge_codes[i])
      foreach (edge_ticks[j])
        send_tick(edge_codes[i], edge_codes[3 - i], edge_ticks[j]);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin send_idle_pct = 30; recv_idle_pct = 79; end
        2: begin send_idle_pct = 79; recv_idle_pct = 30; end
        4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        default: ;
      endcase
      case (phase)
        0: ; // settling period runs on reset settings
        1: load_settings(16'd0, 16'hFFFF, 16'd0, 24'hFF_FFFF, 24'd0, 16'd1,
                         16'hFFFF, 16'd0);
        2: load_settings(16'hFFFF, 16'd0, 16'hFFFF, 24'd0, 24'hFF_FFFF, 16'hFFFF,
                         16'd0, 16'hFFFF);
        3: load_settings(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                         24'($urandom_range(600000)), 16'd0, 16'($urandom_range(20000)),
                         16'($urandom_range(10000)));
        default: load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                               24'($urandom), 24'($urandom_range(600000)),
                               16'($urandom_range(1, 20)), 16'($urandom_range(20000)),
                               16'($urandom_range(10000)));
      endcase
      for (int n = 0; n < 215; n++) begin
        // one long receiver stall while the sender keeps offering
        if (phase == 4 && n == 20) hold_req = 1'b1;
        send_tick(pick_code(), pick_code(), pick_ticks());
      end
      drain();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("tb_battery_monitor_coulomb_counter: clean");
    else
      $display("tb_battery_monitor_coulomb_counter: errors");
    $finish;
  end

endmodule
